// File: hdl/tol_pkg.sv
// Shared types, codes and layout constants for the text overlay layout block.
// Used by text_overlay_layout; depends on nothing else.
`default_nettype none

package tol_pkg;

    localparam int TOL_GLYPHS_PER_BANK = 32;
    localparam int TOL_POSITION_BITS   = 16;
    localparam int TOL_BANKS           = 3;
    localparam int TOL_QUEUE_DEPTH     = 4;

    localparam int TOL_CFG_INDEX_BITS  = 2;
    localparam int TOL_CFG_DATA_BITS   = 10;

    localparam int TOL_WIDTH_LIMIT     = 320;
    localparam int TOL_HEIGHT_LIMIT    = 240;
    localparam int TOL_MARGIN_NARROW   = 16;
    localparam int TOL_MARGIN_WIDE     = 32;
    localparam int TOL_WRAP_GUARD      = 16;
    localparam int TOL_LINE_STEP       = 11;
    localparam int TOL_GLYPH_HEIGHT    = 10;
    localparam int TOL_RUN_PAD         = 2;
    localparam int TOL_SPACE_ADVANCE   = 6;
    localparam int TOL_FIXED_ADVANCE   = 7;
    localparam int TOL_TAB_STOP        = 32;

    // Register indexes of the configuration port.
    localparam logic [TOL_CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [TOL_CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [TOL_CFG_INDEX_BITS-1:0] REG_DRAW_PASS     = 2'd2;

    // Character and control codes.
    localparam logic [7:0] CHR_NUL          = 8'h00;
    localparam logic [7:0] CHR_TAB          = 8'h09;
    localparam logic [7:0] CHR_NEWLINE      = 8'h0A;
    localparam logic [7:0] CHR_SPACE        = 8'h20;
    localparam logic [7:0] CHR_BANK0_FIRST  = 8'h21;
    localparam logic [7:0] CHR_BANK1_FIRST  = 8'h40;
    localparam logic [7:0] CHR_BANK2_FIRST  = 8'h60;
    localparam logic [7:0] CHR_GLYPH_END    = 8'h80;
    localparam logic [7:0] CODE_TEXT_COLOUR = 8'h81;
    localparam logic [7:0] CODE_POSITION    = 8'h82;
    localparam logic [7:0] CODE_FIXED_OFF   = 8'h83;
    localparam logic [7:0] CODE_FIXED_ON    = 8'h84;
    localparam logic [7:0] CODE_BG_COLOUR   = 8'h85;

    localparam logic [1:0] BANK_NONE = 2'd3;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_TEXT  = 2'd1,
        KIND_LOAD  = 2'd2,
        KIND_END   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PEND_NONE        = 2'd0,
        PEND_TEXT_COLOUR = 2'd1,
        PEND_BG_COLOUR   = 2'd2,
        PEND_POSITION    = 2'd3
    } t_pend;

    typedef enum logic [2:0] {
        CMD_FILL_RECT   = 3'd0,
        CMD_TEXT_COLOUR = 3'd1,
        CMD_BG_COLOUR   = 3'd2,
        CMD_SELECT_BANK = 3'd3,
        CMD_GLYPH_QUAD  = 3'd4
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [15:0] left_x;
        logic [15:0] top_y;
        logic [15:0] right_x;
        logic [15:0] bottom_y;
        logic [31:0] rgba;
        logic [1:0]  bank;
        logic [7:0]  col;
        logic        last;
    } t_result;

    // Font bank of a printable byte.
    function automatic logic [1:0] glyph_bank(input logic [7:0] c);
        logic [1:0] b;
        if (c < CHR_BANK1_FIRST) begin
            b = 2'd0;
        end else if (c < CHR_BANK2_FIRST) begin
            b = 2'd1;
        end else begin
            b = 2'd2;
        end
        return b;
    endfunction

    // First byte of a bank.
    function automatic logic [7:0] bank_base(input logic [1:0] b);
        logic [7:0] base;
        case (b)
            2'd0:    base = CHR_BANK0_FIRST;
            2'd1:    base = CHR_BANK1_FIRST;
            default: base = CHR_BANK2_FIRST;
        endcase
        return base;
    endfunction

endpackage

`default_nettype wire

// File: hdl/text_overlay_layout.sv
// Text overlay layout: turns a byte stream with control codes into drawing commands.
// Depends on tol_pkg and tol_ram.
// An accepted beat is registered into stage 1, and its results into the result queue.
// Throughput: one item per cycle while the result queue has room for two results;
// the output drains one result per cycle when ready, so two-result items run slower.
// Reset (synchronous, active low) restores the registers and the layout state;
// the glyph table is not cleared, so an entry reads as garbage until it is loaded.
`default_nettype none

module text_overlay_layout #(
    parameter int GLYPHS_PER_BANK = tol_pkg::TOL_GLYPHS_PER_BANK,
    parameter int POSITION_BITS   = tol_pkg::TOL_POSITION_BITS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // Configuration write channel.
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [tol_pkg::TOL_CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [tol_pkg::TOL_CFG_DATA_BITS-1:0]  i_cfg_data,
    // Input channel: one byte or table load per beat.
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic [1:0]                            i_kind,
    input  wire logic [7:0]                            i_text_byte,
    input  wire logic [6:0]                            i_glyph_slot,
    input  wire logic [7:0]                            i_glyph_first_col,
    input  wire logic [7:0]                            i_glyph_last_col,
    // Output channel: one drawing command per beat.
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic [2:0]                                 o_command,
    output logic [15:0]                                o_left_x,
    output logic [15:0]                                o_top_y,
    output logic [15:0]                                o_right_x,
    output logic [15:0]                                o_bottom_y,
    output logic [31:0]                                o_rgba,
    output logic [1:0]                                 o_font_bank,
    output logic [7:0]                                 o_glyph_col,
    output logic                                       o_last
);

    import tol_pkg::*;

    // Position width, a one-bit-wider width for compares that must not wrap,
    // and the glyph table and result queue geometry.
    localparam int P     = POSITION_BITS;
    localparam int XW    = POSITION_BITS + 1;
    localparam int DEPTH = TOL_BANKS * GLYPHS_PER_BANK;
    localparam int AW    = $clog2(DEPTH);
    localparam int QAW   = $clog2(TOL_QUEUE_DEPTH);
    localparam int QCW   = QAW + 1;

    // ------------------------------------------------------------------
    // Configuration registers. The user may write them only while the block
    // is idle; the block itself does not enforce this. The port is always ready.
    // ------------------------------------------------------------------
    logic [9:0] r_sw;
    logic [9:0] r_sh;
    logic       r_pass;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw   <= 10'(TOL_WIDTH_LIMIT);
            r_sh   <= 10'(TOL_HEIGHT_LIMIT);
            r_pass <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SCREEN_WIDTH:  r_sw   <= i_cfg_data;
                REG_SCREEN_HEIGHT: r_sh   <= i_cfg_data;
                REG_DRAW_PASS:     r_pass <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Margins follow the screen size.
    logic [P-1:0] w_left_margin;
    logic [P-1:0] w_top_margin;

    assign w_left_margin = (r_sw <= 10'(TOL_WIDTH_LIMIT))  ? P'(TOL_MARGIN_NARROW)
                                                           : P'(TOL_MARGIN_WIDE);
    assign w_top_margin  = (r_sh <= 10'(TOL_HEIGHT_LIMIT)) ? P'(TOL_MARGIN_NARROW)
                                                           : P'(TOL_MARGIN_WIDE);

    // ------------------------------------------------------------------
    // Stage 0: accept the beat. A table load writes the glyph memory at once;
    // every beat issues a read of the entry its byte would use, so the entry
    // is ready when the item reaches stage 1. A load followed directly by a
    // byte of the same glyph is safe, as the write lands on the edge before
    // the read.
    // ------------------------------------------------------------------
    logic          w_in_fire;
    logic          w_s1_fire;
    logic          r_s1_valid;
    t_kind         r_s1_kind;
    logic [7:0]    r_s1_byte;

    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [15:0]   w_wr_data;
    logic [AW-1:0] w_rd_addr;
    logic [1:0]    w_in_bank;
    logic [7:0]    w_in_index;
    logic [15:0]   w_glyph_entry;

    assign o_in_ready = !r_s1_valid || w_s1_fire;
    assign w_in_fire  = i_in_valid && o_in_ready;

    assign w_in_bank  = glyph_bank(i_text_byte);
    assign w_in_index = i_text_byte - bank_base(w_in_bank);
    assign w_rd_addr  = AW'(32'(w_in_bank) * GLYPHS_PER_BANK + 32'(w_in_index));

    assign w_wr_en   = w_in_fire && (t_kind'(i_kind) == KIND_LOAD)
                       && (32'(i_glyph_slot) < DEPTH);
    assign w_wr_addr = AW'(i_glyph_slot);
    assign w_wr_data = {i_glyph_last_col, i_glyph_first_col};

    tol_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_glyph_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_in_fire),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_glyph_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_kind <= t_kind'(i_kind);
            r_s1_byte <= i_text_byte;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: the layout state. The item reads the state and the glyph
    // entry, works out up to two commands and writes the state back in the
    // same cycle, so the next item sees the updated cursor without a stall.
    // The item only commits when the result queue can take two commands.
    // ------------------------------------------------------------------
    logic [P-1:0] r_cx, r_cy, r_rx, r_ry;
    logic         r_fw;
    logic [1:0]   r_lb;
    t_pend        r_pc;
    logic [1:0]   r_oc;
    logic [31:0]  r_ob;

    logic [P-1:0] n_cx, n_cy, n_rx, n_ry;
    logic         n_fw;
    logic [1:0]   n_lb;
    t_pend        n_pc;
    logic [1:0]   n_oc;
    logic [31:0]  n_ob;

    t_result      w_ea, w_eb;
    logic         w_ea_v, w_eb_v;

    logic [QCW-1:0] r_cnt;

    assign w_s1_fire = r_s1_valid && (r_cnt <= QCW'(TOL_QUEUE_DEPTH - 2));

    // A background run is only drawn if it has some width and height.
    function automatic logic run_open(input logic [P-1:0] cx, input logic [P-1:0] cy,
                                      input logic [P-1:0] rx, input logic [P-1:0] ry);
        logic [XW-1:0] lry;
        lry = XW'(cy) + XW'(TOL_GLYPH_HEIGHT);
        return (rx != cx) && (XW'(ry) != lry);
    endfunction

    function automatic t_result run_rect(input logic [P-1:0] cx, input logic [P-1:0] cy,
                                         input logic [P-1:0] rx, input logic [P-1:0] ry);
        t_result r;
        r          = '0;
        r.cmd      = CMD_FILL_RECT;
        r.left_x   = (rx >= P'(TOL_RUN_PAD)) ? 16'(rx - P'(TOL_RUN_PAD)) : 16'(rx);
        r.top_y    = 16'(ry);
        r.right_x  = 16'(cx) + 16'(TOL_RUN_PAD);
        r.bottom_y = 16'(cy) + 16'(TOL_GLYPH_HEIGHT);
        return r;
    endfunction

    always_comb begin
        logic [7:0]   c;
        logic [31:0]  ob_next;
        logic [P-1:0] dx;
        logic [P-1:0] adv_x;
        logic         adv;
        logic         printable;
        logic [1:0]   bank;
        logic [7:0]   first_col;
        logic [7:0]   last_col;

        c         = r_s1_byte;
        ob_next   = {r_ob[23:0], r_s1_byte};
        dx        = '0;
        adv_x     = '0;
        adv       = 1'b0;
        printable = (c >= CHR_SPACE) && (c < CHR_GLYPH_END);
        bank      = glyph_bank(c);
        first_col = w_glyph_entry[7:0];
        last_col  = w_glyph_entry[15:8];

        n_cx = r_cx;
        n_cy = r_cy;
        n_rx = r_rx;
        n_ry = r_ry;
        n_fw = r_fw;
        n_lb = r_lb;
        n_pc = r_pc;
        n_oc = r_oc;
        n_ob = r_ob;

        w_ea   = '0;
        w_eb   = '0;
        w_ea_v = 1'b0;
        w_eb_v = 1'b0;

        unique case (r_s1_kind)
            KIND_START: begin
                n_cx = w_left_margin;
                n_cy = w_top_margin;
                n_rx = w_left_margin;
                n_ry = w_top_margin;
                n_fw = 1'b0;
                n_lb = BANK_NONE;
                n_pc = PEND_NONE;
                n_oc = '0;
                n_ob = '0;
            end
            KIND_TEXT: begin
                if (r_pc != PEND_NONE) begin
                    // Operand byte: the fourth one carries out the pending code.
                    if (r_oc == 2'd3) begin
                        unique case (r_pc)
                            PEND_TEXT_COLOUR: begin
                                w_ea.cmd  = CMD_TEXT_COLOUR;
                                w_ea.rgba = ob_next;
                                w_ea_v    = r_pass;
                            end
                            PEND_BG_COLOUR: begin
                                w_ea.cmd  = CMD_BG_COLOUR;
                                w_ea.rgba = ob_next;
                                w_ea_v    = !r_pass;
                            end
                            PEND_POSITION: begin
                                n_cx = P'({ob_next[23:16], ob_next[31:24]});
                                n_cy = P'({ob_next[7:0], ob_next[15:8]});
                                n_rx = P'({ob_next[23:16], ob_next[31:24]});
                                n_ry = P'({ob_next[7:0], ob_next[15:8]});
                            end
                            default: ;
                        endcase
                        n_pc = PEND_NONE;
                        n_oc = '0;
                        n_ob = '0;
                        adv  = 1'b1;
                    end else begin
                        n_ob = ob_next;
                        n_oc = r_oc + 2'd1;
                    end
                end else if (c == CHR_NUL) begin
                    // Zero bytes are dropped without a wrap check.
                end else if (c == CODE_TEXT_COLOUR || c == CODE_BG_COLOUR
                             || c == CODE_POSITION) begin
                    n_pc = (c == CODE_TEXT_COLOUR) ? PEND_TEXT_COLOUR :
                           (c == CODE_BG_COLOUR)   ? PEND_BG_COLOUR : PEND_POSITION;
                    n_oc = '0;
                    n_ob = '0;
                    if (c == CODE_POSITION) begin
                        w_ea   = run_rect(r_cx, r_cy, r_rx, r_ry);
                        w_ea_v = !r_pass && run_open(r_cx, r_cy, r_rx, r_ry);
                    end
                end else begin
                    adv = 1'b1;
                    case (c)
                        CODE_FIXED_OFF: n_fw = 1'b0;
                        CODE_FIXED_ON:  n_fw = 1'b1;
                        CHR_SPACE:      dx   = P'(TOL_SPACE_ADVANCE);
                        CHR_TAB:        dx   = P'(TOL_TAB_STOP)
                                               - (r_cx & P'(TOL_TAB_STOP - 1));
                        CHR_NEWLINE: begin
                            w_ea   = run_rect(r_cx, r_cy, r_rx, r_ry);
                            w_ea_v = !r_pass && run_open(r_cx, r_cy, r_rx, r_ry);
                            n_cx   = w_left_margin;
                            n_cy   = r_cy + P'(TOL_LINE_STEP);
                            n_rx   = w_left_margin;
                            n_ry   = r_cy + P'(TOL_LINE_STEP);
                        end
                        default: begin
                            if (c >= CHR_BANK0_FIRST && c < CHR_GLYPH_END) begin
                                // Width comes from the glyph's columns and wraps.
                                dx = P'(last_col) - P'(first_col) + P'(1);
                                if (r_pass) begin
                                    if (bank != r_lb) begin
                                        w_ea.cmd  = CMD_SELECT_BANK;
                                        w_ea.bank = bank;
                                        w_ea_v    = 1'b1;
                                        n_lb      = bank;
                                    end
                                    w_eb.cmd      = CMD_GLYPH_QUAD;
                                    w_eb.left_x   = 16'(r_cx);
                                    w_eb.top_y    = 16'(r_cy);
                                    w_eb.right_x  = 16'(r_cx) + 16'(dx);
                                    w_eb.bottom_y = 16'(r_cy) + 16'(TOL_GLYPH_HEIGHT);
                                    w_eb.bank     = bank;
                                    w_eb.col      = first_col;
                                    w_eb_v        = 1'b1;
                                end
                            end
                        end
                    endcase
                    if (n_fw && printable) begin
                        dx = P'(TOL_FIXED_ADVANCE);
                    end
                end
            end
            KIND_LOAD: ;
            KIND_END: begin
                w_ea   = run_rect(r_cx, r_cy, r_rx, r_ry);
                w_ea_v = !r_pass && run_open(r_cx, r_cy, r_rx, r_ry);
                n_pc   = PEND_NONE;
                n_oc   = '0;
                n_ob   = '0;
            end
            default: ;
        endcase

        // Advance and wrap check. A wrap is a newline that first closes the run
        // in the background pass; glyph quads only occur in the other pass, so
        // the second result slot is never claimed twice.
        if (adv) begin
            adv_x = n_cx + dx;
            n_cx  = adv_x;
            if ((XW'(adv_x) + XW'(TOL_WRAP_GUARD)) > XW'(r_sw)) begin
                if (!r_pass) begin
                    w_eb   = run_rect(adv_x, n_cy, n_rx, n_ry);
                    w_eb_v = run_open(adv_x, n_cy, n_rx, n_ry);
                end
                n_cx = w_left_margin;
                n_rx = w_left_margin;
                n_cy = n_cy + P'(TOL_LINE_STEP);
                n_ry = n_cy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= P'(TOL_MARGIN_NARROW);
            r_cy <= P'(TOL_MARGIN_NARROW);
            r_rx <= P'(TOL_MARGIN_NARROW);
            r_ry <= P'(TOL_MARGIN_NARROW);
            r_fw <= 1'b0;
            r_lb <= BANK_NONE;
            r_pc <= PEND_NONE;
            r_oc <= '0;
            r_ob <= '0;
        end else if (w_s1_fire) begin
            r_cx <= n_cx;
            r_cy <= n_cy;
            r_rx <= n_rx;
            r_ry <= n_ry;
            r_fw <= n_fw;
            r_lb <= n_lb;
            r_pc <= n_pc;
            r_oc <= n_oc;
            r_ob <= n_ob;
        end
    end

    // ------------------------------------------------------------------
    // Result queue. Stage 1 pushes zero, one or two commands at once; the
    // output takes one per beat. The queue also parts the two sides, so new
    // items keep flowing while results wait, as long as it has room for two.
    // ------------------------------------------------------------------
    t_result        r_q [TOL_QUEUE_DEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic           w_pop;
    logic [1:0]     w_push_n;
    t_result        w_pk0;
    t_result        w_pk1;

    always_comb begin
        w_push_n = {1'b0, w_ea_v} + {1'b0, w_eb_v};
        w_pk0    = w_ea_v ? w_ea : w_eb;
        w_pk1    = w_eb;
        w_pk0.last = (w_push_n == 2'd1);
        w_pk1.last = 1'b1;
        if (!w_s1_fire) begin
            w_push_n = 2'd0;
        end
    end

    assign o_out_valid = (r_cnt != '0);
    assign w_pop       = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + QAW'(w_push_n);
            r_rp  <= r_rp + QAW'(w_pop);
            r_cnt <= r_cnt + QCW'(w_push_n) - QCW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_n != 2'd0) begin
            r_q[r_wp] <= w_pk0;
        end
        if (w_push_n == 2'd2) begin
            r_q[r_wp + QAW'(1)] <= w_pk1;
        end
    end

    assign o_command   = r_q[r_rp].cmd;
    assign o_left_x    = r_q[r_rp].left_x;
    assign o_top_y     = r_q[r_rp].top_y;
    assign o_right_x   = r_q[r_rp].right_x;
    assign o_bottom_y  = r_q[r_rp].bottom_y;
    assign o_rgba      = r_q[r_rp].rgba;
    assign o_font_bank = r_q[r_rp].bank;
    assign o_glyph_col = r_q[r_rp].col;
    assign o_last      = r_q[r_rp].last;

endmodule

`default_nettype wire

// File: hdl/tol_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module tol_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 96
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire
